### rtl/shs_pkg.sv
// shs_pkg: shared codes and types of the servo homing sequencer
// sequencer state codes, reply codes, error reasons and the step result struct
// no dependencies
`default_nettype none

package shs_pkg;

  // sequencer states
  localparam logic [3:0] ST_INIT       = 4'd0;
  localparam logic [3:0] ST_IDLE       = 4'd1;
  localparam logic [3:0] ST_COMMANDED  = 4'd2;
  localparam logic [3:0] ST_SET_PARAMS = 4'd3;
  localparam logic [3:0] ST_PARAMS_SET = 4'd4;
  localparam logic [3:0] ST_SET_MODES  = 4'd5;
  localparam logic [3:0] ST_HOMING     = 4'd6;
  localparam logic [3:0] ST_RESTORING  = 4'd7;
  localparam logic [3:0] ST_ATTAINED   = 4'd8;
  localparam logic [3:0] ST_ERROR      = 4'd9;
  localparam logic [3:0] ST_INT_ERROR  = 4'd10;

  // request reply codes
  localparam logic [2:0] RP_PENDING   = 3'd0;
  localparam logic [2:0] RP_DONE      = 3'd1;
  localparam logic [2:0] RP_FAILED    = 3'd2;
  localparam logic [2:0] RP_CANCELLED = 3'd3;
  localparam logic [2:0] RP_CHECKFAIL = 3'd4;

  // homing status codes
  localparam logic [2:0] HS_UNKNOWN     = 3'd0;
  localparam logic [2:0] HS_NOT_STARTED = 3'd1;
  localparam logic [2:0] HS_IN_PROGRESS = 3'd2;
  localparam logic [2:0] HS_ATTAINED    = 3'd3;
  localparam logic [2:0] HS_ERROR       = 3'd4;

  // mode requests
  localparam logic [1:0] RM_NONE         = 2'd0;
  localparam logic [1:0] RM_CYCLIC       = 2'd1;
  localparam logic [1:0] RM_HOMING       = 2'd2;
  localparam logic [1:0] RM_CYCLIC_SETTL = 2'd3;

  // error reasons
  localparam logic [3:0] ER_NONE           = 4'd0;
  localparam logic [3:0] ER_OP_DISABLED    = 4'd1;
  localparam logic [3:0] ER_REPEATED_CMD   = 4'd2;
  localparam logic [3:0] ER_PARAM_REFUSED  = 4'd3;
  localparam logic [3:0] ER_PARAM_CHECK    = 4'd4;
  localparam logic [3:0] ER_PARAM_CANCEL   = 4'd5;
  localparam logic [3:0] ER_PARAM_FAILED   = 4'd6;
  localparam logic [3:0] ER_MODE_REFUSED   = 4'd7;
  localparam logic [3:0] ER_MODE_CHECK     = 4'd8;
  localparam logic [3:0] ER_MODE_CANCEL    = 4'd9;
  localparam logic [3:0] ER_MODE_FAILED    = 4'd10;
  localparam logic [3:0] ER_DEVICE_HOMING  = 4'd11;
  localparam logic [3:0] ER_RESTORE_REPLY  = 4'd12;

  // status word bits
  localparam logic [15:0] SW_OP_EN_MASK  = 16'h006F;
  localparam logic [15:0] SW_OP_EN_VALUE = 16'h0027;
  localparam int unsigned SW_TARGET_BIT  = 10;
  localparam int unsigned SW_ATTAIN_BIT  = 12;
  localparam int unsigned SW_HERROR_BIT  = 13;
  localparam int unsigned CW_HOMING_BIT  = 4;

  // outcome of one control cycle
  typedef struct packed {
    logic [3:0] state;
    logic       cmd_valid;
    logic       store_cmd;
    logic [3:0] error_code;
    logic [2:0] hstat;
    logic       req_params;
    logic [1:0] req_mode;
  } step_res_t;

endpackage

`default_nettype wire

### rtl/servo_homing_sequencer.sv
// servo_homing_sequencer: ds402 homing-mode sequencer, top level
// holds sequencer state, stored command and the result register
// depends on shs_pkg and shs_step
`default_nettype none

// channel   direction  handshake            payload
// in_       input      in_valid / in_stall   status, control word, command, replies
// out_      output     out_valid / out_stall control word, status, error, requests
//
// one transaction in gives one transaction out, in the cycle after it is taken
// the state update and decode sit between the state registers and the result
// register, so a transaction can be taken on every clock while in_stall is low
// in_stall is raised only while a result is held and out_stall is high
// synchronous active-low reset returns the sequencer to init with no stored
// command, no error reason and an empty result register

module servo_homing_sequencer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [15:0]        in_status_word,
  input  wire logic [15:0]        in_control_word_in,
  input  wire logic               in_command_updated,
  input  wire logic signed [7:0]  in_cmd_method,
  input  wire logic signed [31:0] in_cmd_offset,
  input  wire logic [31:0]        in_cmd_search_speed,
  input  wire logic [31:0]        in_cmd_creep_speed,
  input  wire logic [31:0]        in_cmd_accel,
  input  wire logic               in_launch_refused,
  input  wire logic [2:0]         in_params_reply,
  input  wire logic [2:0]         in_modes_reply,
  input  wire logic               in_mode_is_home,
  // result channel
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [15:0]        out_control_word_out,
  output      logic [2:0]         out_homing_status,
  output      logic [3:0]         out_error_reason,
  output      logic               out_request_params,
  output      logic [1:0]         out_request_mode,
  output      logic signed [7:0]  out_write_method,
  output      logic signed [31:0] out_write_offset,
  output      logic [31:0]        out_write_search_speed,
  output      logic [31:0]        out_write_creep_speed,
  output      logic [31:0]        out_write_accel
);

  // sequencer state
  logic [3:0]         state_r;
  logic               cmd_valid_r;
  logic [3:0]         err_r;
  // stored command, meaningful only while cmd_valid_r is set
  logic signed [7:0]  last_method_r;
  logic signed [31:0] last_offset_r;
  logic [31:0]        last_search_r;
  logic [31:0]        last_creep_r;
  logic [31:0]        last_accel_r;

  // result register
  logic               out_valid_r;
  logic [15:0]        cw_r;
  logic [2:0]         hs_r;
  logic [3:0]         er_r;
  logic               rq_p_r;
  logic [1:0]         rq_m_r;
  logic signed [7:0]  wr_method_r;
  logic signed [31:0] wr_offset_r;
  logic [31:0]        wr_search_r;
  logic [31:0]        wr_creep_r;
  logic [31:0]        wr_accel_r;

  logic               accept;
  logic               cmd_match;
  logic [15:0]        cw_nxt;
  shs_pkg::step_res_t step;

  // result register frees as soon as the held result is taken
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // repeated command detection against the stored copy
  assign cmd_match = (last_method_r == in_cmd_method) &&
                     (last_offset_r == in_cmd_offset) &&
                     (last_search_r == in_cmd_search_speed) &&
                     (last_creep_r == in_cmd_creep_speed) &&
                     (last_accel_r == in_cmd_accel);

  shs_step u_step (
    .state            (state_r),
    .cmd_valid        (cmd_valid_r),
    .cmd_match        (cmd_match),
    .last_method_zero (last_method_r == 8'sd0),
    .drive_sw         (in_status_word),
    .command_updated  (in_command_updated),
    .method_nonzero   (in_cmd_method != 8'sd0),
    .launch_refused   (in_launch_refused),
    .params_reply     (in_params_reply),
    .modes_reply      (in_modes_reply),
    .mode_is_home     (in_mode_is_home),
    .error_code       (err_r),
    .res              (step)
  );

  // homing bit follows the new state
  always_comb begin
    cw_nxt = in_control_word_in;
    cw_nxt[shs_pkg::CW_HOMING_BIT] = (step.state == shs_pkg::ST_HOMING);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= shs_pkg::ST_INIT;
      cmd_valid_r <= 1'b0;
      err_r       <= shs_pkg::ER_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= step.state;
        cmd_valid_r <= step.cmd_valid;
        err_r       <= step.error_code;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // stored command and result payload
  always_ff @(posedge clk) begin
    if (accept && step.store_cmd) begin
      last_method_r <= in_cmd_method;
      last_offset_r <= in_cmd_offset;
      last_search_r <= in_cmd_search_speed;
      last_creep_r  <= in_cmd_creep_speed;
      last_accel_r  <= in_cmd_accel;
    end
    if (accept) begin
      cw_r   <= cw_nxt;
      hs_r   <= step.hstat;
      er_r   <= step.error_code;
      rq_p_r <= step.req_params;
      rq_m_r <= step.req_mode;
      // the parameter strobe carries the command just stored, zero otherwise
      wr_method_r <= step.req_params ? in_cmd_method       : 8'sd0;
      wr_offset_r <= step.req_params ? in_cmd_offset       : 32'sd0;
      wr_search_r <= step.req_params ? in_cmd_search_speed : 32'd0;
      wr_creep_r  <= step.req_params ? in_cmd_creep_speed  : 32'd0;
      wr_accel_r  <= step.req_params ? in_cmd_accel        : 32'd0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_control_word_out   = cw_r;
  assign out_homing_status      = hs_r;
  assign out_error_reason       = er_r;
  assign out_request_params     = rq_p_r;
  assign out_request_mode       = rq_m_r;
  assign out_write_method       = wr_method_r;
  assign out_write_offset       = wr_offset_r;
  assign out_write_search_speed = wr_search_r;
  assign out_write_creep_speed  = wr_creep_r;
  assign out_write_accel        = wr_accel_r;

endmodule

`default_nettype wire

### rtl/shs_step.sv
// shs_step: next-state and output decode for one control cycle
// depends on shs_pkg
`default_nettype none

module shs_step (
  input  wire logic [3:0]         state,
  input  wire logic               cmd_valid,
  input  wire logic               cmd_match,
  input  wire logic               last_method_zero,
  input  wire logic [15:0]        drive_sw,
  input  wire logic               command_updated,
  input  wire logic               method_nonzero,
  input  wire logic               launch_refused,
  input  wire logic [2:0]         params_reply,
  input  wire logic [2:0]         modes_reply,
  input  wire logic               mode_is_home,
  input  wire logic [3:0]         error_code,
  output shs_pkg::step_res_t      res
);

  logic       op_en;
  logic [2:0] prep;
  logic [2:0] mrep;
  logic [3:0] nst;
  logic [3:0] err;
  logic       vld;
  logic       store;
  logic       rq_p;
  logic [1:0] rq_m;
  logic [2:0] hs;

  assign op_en = (drive_sw & shs_pkg::SW_OP_EN_MASK) == shs_pkg::SW_OP_EN_VALUE;
  // reply codes above check failure count as failed
  assign prep  = (params_reply > shs_pkg::RP_CHECKFAIL) ? shs_pkg::RP_FAILED : params_reply;
  assign mrep  = (modes_reply > shs_pkg::RP_CHECKFAIL) ? shs_pkg::RP_FAILED : modes_reply;

  always_comb begin
    nst   = state;
    err   = error_code;
    vld   = cmd_valid;
    store = 1'b0;
    rq_p  = 1'b0;
    rq_m  = shs_pkg::RM_NONE;
    unique case (state)
      shs_pkg::ST_IDLE: begin
        if (command_updated && method_nonzero) nst = shs_pkg::ST_COMMANDED;
      end
      shs_pkg::ST_COMMANDED: begin
        if (!op_en) begin
          nst = shs_pkg::ST_ERROR;
          err = shs_pkg::ER_OP_DISABLED;
        end else if (cmd_valid && cmd_match) begin
          nst = shs_pkg::ST_ERROR;
          err = shs_pkg::ER_REPEATED_CMD;
        end else begin
          vld   = 1'b1;
          store = 1'b1;
          rq_p  = 1'b1;
          if (launch_refused) begin
            nst = shs_pkg::ST_ERROR;
            err = shs_pkg::ER_PARAM_REFUSED;
          end else begin
            nst = shs_pkg::ST_SET_PARAMS;
          end
        end
      end
      shs_pkg::ST_SET_PARAMS: begin
        if (!op_en) begin
          nst = shs_pkg::ST_ERROR;
          err = shs_pkg::ER_OP_DISABLED;
        end else begin
          case (prep)
            shs_pkg::RP_CHECKFAIL: begin
              nst = shs_pkg::ST_INT_ERROR;
              err = shs_pkg::ER_PARAM_CHECK;
            end
            shs_pkg::RP_CANCELLED: begin
              nst = shs_pkg::ST_ERROR;
              err = shs_pkg::ER_PARAM_CANCEL;
            end
            shs_pkg::RP_FAILED: begin
              nst = shs_pkg::ST_ERROR;
              err = shs_pkg::ER_PARAM_FAILED;
            end
            shs_pkg::RP_DONE: begin
              nst = last_method_zero ? shs_pkg::ST_IDLE : shs_pkg::ST_PARAMS_SET;
            end
            default: ;
          endcase
        end
      end
      shs_pkg::ST_PARAMS_SET: begin
        if (!op_en) begin
          nst = shs_pkg::ST_ERROR;
          err = shs_pkg::ER_OP_DISABLED;
        end else begin
          rq_m = shs_pkg::RM_HOMING;
          if (launch_refused) begin
            nst = shs_pkg::ST_ERROR;
            err = shs_pkg::ER_MODE_REFUSED;
          end else begin
            nst = shs_pkg::ST_SET_MODES;
          end
        end
      end
      shs_pkg::ST_SET_MODES: begin
        if (!op_en) begin
          nst = shs_pkg::ST_ERROR;
          err = shs_pkg::ER_OP_DISABLED;
        end else begin
          case (mrep)
            shs_pkg::RP_CHECKFAIL: begin
              nst = shs_pkg::ST_INT_ERROR;
              err = shs_pkg::ER_MODE_CHECK;
            end
            shs_pkg::RP_CANCELLED: begin
              nst = shs_pkg::ST_ERROR;
              err = shs_pkg::ER_MODE_CANCEL;
            end
            shs_pkg::RP_FAILED: begin
              nst = shs_pkg::ST_ERROR;
              err = shs_pkg::ER_MODE_FAILED;
            end
            shs_pkg::RP_DONE: begin
              nst = mode_is_home ? shs_pkg::ST_HOMING : shs_pkg::ST_IDLE;
            end
            default: ;
          endcase
        end
      end
      shs_pkg::ST_HOMING: begin
        if (!op_en) begin
          nst = shs_pkg::ST_ERROR;
          err = shs_pkg::ER_OP_DISABLED;
        end else if (drive_sw[shs_pkg::SW_HERROR_BIT]) begin
          nst = shs_pkg::ST_ERROR;
          err = shs_pkg::ER_DEVICE_HOMING;
        end else if (drive_sw[shs_pkg::SW_TARGET_BIT] &&
                     drive_sw[shs_pkg::SW_ATTAIN_BIT]) begin
          rq_m = shs_pkg::RM_CYCLIC_SETTL;
          if (launch_refused) begin
            nst = shs_pkg::ST_ERROR;
            err = shs_pkg::ER_MODE_REFUSED;
          end else begin
            nst = shs_pkg::ST_RESTORING;
          end
        end
      end
      shs_pkg::ST_RESTORING: begin
        if (!op_en) begin
          nst = shs_pkg::ST_ERROR;
          err = shs_pkg::ER_OP_DISABLED;
        end else if (mrep == shs_pkg::RP_DONE || mrep == shs_pkg::RP_FAILED) begin
          nst = shs_pkg::ST_ATTAINED;
        end else if (mrep != shs_pkg::RP_PENDING) begin
          nst = shs_pkg::ST_ERROR;
          err = shs_pkg::ER_RESTORE_REPLY;
        end
      end
      shs_pkg::ST_ATTAINED: begin
        nst = shs_pkg::ST_IDLE;
      end
      default: begin
        // init, both error states and unused codes
        if (!op_en) begin
          nst = shs_pkg::ST_INIT;
        end else begin
          rq_m = shs_pkg::RM_CYCLIC;
          if (launch_refused) begin
            nst = shs_pkg::ST_ERROR;
            err = shs_pkg::ER_MODE_REFUSED;
          end else begin
            nst = shs_pkg::ST_SET_MODES;
          end
        end
      end
    endcase

    // status from the new state; stored command dropped outside the run
    unique case (nst) inside
      shs_pkg::ST_SET_PARAMS, shs_pkg::ST_PARAMS_SET, shs_pkg::ST_SET_MODES,
      shs_pkg::ST_HOMING, shs_pkg::ST_RESTORING: hs = shs_pkg::HS_IN_PROGRESS;
      shs_pkg::ST_ATTAINED:  hs = shs_pkg::HS_ATTAINED;
      shs_pkg::ST_COMMANDED: hs = shs_pkg::HS_NOT_STARTED;
      shs_pkg::ST_ERROR, shs_pkg::ST_INT_ERROR: begin
        hs  = shs_pkg::HS_ERROR;
        vld = 1'b0;
      end
      default: begin
        hs  = shs_pkg::HS_UNKNOWN;
        vld = 1'b0;
      end
    endcase
  end

  assign res.state      = nst;
  assign res.cmd_valid  = vld;
  assign res.store_cmd  = store;
  assign res.error_code = err;
  assign res.hstat      = hs;
  assign res.req_params = rq_p;
  assign res.req_mode   = rq_m;

endmodule

`default_nettype wire
